// ===== hdl/tls_client_hello_sni_extractor_unit_defines.svh =====
// Assertion macros for the TLS server name extractor.
`ifndef TLS_CLIENT_HELLO_SNI_EXTRACTOR_UNIT_DEFINES_SVH
`define TLS_CLIENT_HELLO_SNI_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TLSSNI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlssni: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define TLSSNI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlssni: next-cycle check failed");

`endif

// ===== hdl/tlssni_pkg.sv =====
// Shared types and constants of the TLS server name extractor.
package tlssni_pkg;

  // Captured length width and mask
  localparam int LEN_BITS = 16;
  localparam logic [15:0] LEN_MASK = 16'((32'd1 << LEN_BITS) - 32'd1);

  // Offset width of stored bounds and width of bound sums
  localparam int OFF_W = 18;
  localparam int SUM_W = 20;

  // Protocol constants
  localparam logic [7:0]  TLS_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
  localparam logic [7:0]  HOST_NAME_TYPE  = 8'h00;
  localparam int          SESSION_ID_AT   = 9 + 2 + 32;
  localparam int          MIN_RECORD      = 9;

  // Queue between parser and output side
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result kinds
  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HEADER,
    PH_SESSION,
    PH_CIPHERS,
    PH_COMPRESS,
    PH_EXTLEN,
    PH_EXTHDR,
    PH_SNIHDR,
    PH_NAME,
    PH_IDLE
  } phase_t;

  // One queued word: a name byte, a verdict, or both
  typedef struct packed {
    logic        has_name;
    logic [7:0]  name_byte;
    logic        name_last;
    logic        has_verdict;
    logic        found;
    logic [15:0] name_length;
  } entry_t;

  // Queue status seen by the other parts
  typedef struct packed {
    logic              full;
    logic              valid;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

// ===== hdl/tls_client_hello_sni_extractor_unit.sv =====
// Top level of the TLS ClientHello server name extractor.
// Takes one payload byte per cycle while the queue has room; each result is registered in
// the queue and then in the output register. The parser stalls input only while the
// four-word queue is full; a name that ends on the packet's last byte gives two results
// from one word and uses the output twice. Synchronous active-low reset returns the
// parser to the record header and empties the queue and the output register.
`include "tls_client_hello_sni_extractor_unit_defines.svh"
module tls_client_hello_sni_extractor_unit
  import tlssni_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic [15:0] in_payload_length,
  input  logic        in_packet_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_name_byte,
  output logic        out_name_last,
  output logic        out_found,
  output logic [15:0] out_name_length
);

  logic   accept;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;
  qstat_t qstat;

  // Input taken whenever the queue has room
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  tlssni_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .byte_value     (in_byte_value),
    .payload_length (in_payload_length),
    .packet_last    (in_packet_last),
    .push           (push),
    .entry          (push_entry)
  );

  tlssni_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (qstat)
  );

  tlssni_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (qstat.valid),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_name_byte   (out_name_byte),
    .out_name_last   (out_name_last),
    .out_found       (out_found),
    .out_name_length (out_name_length)
  );

  // Checks
  `TLSSNI_ASSERT_NOW(a_name_word_clean, out_valid && out_result_kind == KIND_NAME, !out_found && out_name_length == 16'd0)
  `TLSSNI_ASSERT_NOW(a_verdict_clean, out_valid && out_result_kind == KIND_VERDICT, out_name_byte == 8'd0 && !out_name_last)
  `TLSSNI_ASSERT_NOW(a_found_nonempty, out_valid && out_result_kind == KIND_VERDICT && out_found, out_name_length != 16'd0)
  `TLSSNI_ASSERT_NEXT(a_verdict_queued, accept && in_packet_last, qstat.count != '0)

endmodule

// ===== hdl/tlssni_front.sv =====
// Byte parser: walks the ClientHello and queues a word for each name byte and for the packet's last byte.
module tlssni_front
  import tlssni_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  byte_value,
  input  logic [15:0] payload_length,
  input  logic        packet_last,
  output logic        push,
  output entry_t      entry
);

  phase_t           phase_r, phase_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [15:0]      held_r, held_nxt;
  logic [OFF_W-1:0] target_r, target_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [OFF_W-1:0] ext_end_r, ext_end_nxt;
  logic [15:0]      ext_kind_r, ext_kind_nxt;
  logic [OFF_W-1:0] name_end_r, name_end_nxt;
  logic             found_r, found_nxt;
  logic [15:0]      found_len_r, found_len_nxt;

  logic [15:0]      plen_m;
  logic [15:0]      len_cur;
  logic [OFF_W-1:0] pos18;
  logic [15:0]      val16;
  logic             hit0, hit1, hit2, hit3, hit4;
  logic             in_name, name_fin;
  logic [15:0]      name_len_now;
  logic [SUM_W-1:0] off, sum, lenx, extx;

  // Common terms
  assign plen_m  = payload_length & LEN_MASK;
  assign len_cur = (pos_r == 16'd0) ? plen_m : held_r;
  assign pos18   = {2'b00, pos_r};
  assign val16   = {acc_r[15:8], byte_value};
  assign lenx    = SUM_W'(len_cur);
  assign extx    = SUM_W'(ext_end_r);
  assign hit0    = (pos18 == target_r);
  assign hit1    = (pos18 == target_r + OFF_W'(1));
  assign hit2    = (pos18 == target_r + OFF_W'(2));
  assign hit3    = (pos18 == target_r + OFF_W'(3));
  assign hit4    = (pos18 == target_r + OFF_W'(4));

  // Name window
  assign in_name  = (phase_r == PH_NAME) && (pos18 >= target_r) && (pos18 < name_end_r);
  assign name_fin = ((SUM_W'(pos_r) + SUM_W'(1)) == SUM_W'(name_end_r));
  assign name_len_now = 16'(name_end_r - target_r) & LEN_MASK;

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    held_nxt      = held_r;
    target_nxt    = target_r;
    acc_nxt       = acc_r;
    ext_end_nxt   = ext_end_r;
    ext_kind_nxt  = ext_kind_r;
    name_end_nxt  = name_end_r;
    found_nxt     = found_r;
    found_len_nxt = found_len_r;
    off           = '0;
    sum           = '0;
    if (accept) begin
      if (pos_r == 16'd0) begin
        held_nxt = plen_m;
      end
      case (phase_r)
        PH_HEADER: begin
          if (pos_r == 16'd0) begin
            if (len_cur < 16'(MIN_RECORD) || byte_value != TLS_HANDSHAKE) begin
              phase_nxt = PH_IDLE;
            end
          end else if (pos_r == 16'd3) begin
            acc_nxt = {byte_value, 8'h00};
          end else if (pos_r == 16'd4) begin
            acc_nxt = val16;
          end else if (pos_r == 16'd5) begin
            if ((SUM_W'(5) + SUM_W'(acc_r)) > lenx || byte_value != HS_CLIENT_HELLO ||
                SUM_W'(SESSION_ID_AT) >= lenx) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt  = PH_SESSION;
              target_nxt = OFF_W'(SESSION_ID_AT);
            end
          end
        end
        PH_SESSION, PH_COMPRESS: begin
          if (hit0) begin
            off = SUM_W'(target_r) + SUM_W'(1) + SUM_W'(byte_value);
            if (off + SUM_W'(2) > lenx) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt  = (phase_r == PH_SESSION) ? PH_CIPHERS : PH_EXTLEN;
              target_nxt = OFF_W'(off);
            end
          end
        end
        PH_CIPHERS: begin
          if (hit0) begin
            acc_nxt = {byte_value, 8'h00};
          end else if (hit1) begin
            off = SUM_W'(target_r) + SUM_W'(2) + SUM_W'(val16);
            if (off + SUM_W'(1) > lenx) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt  = PH_COMPRESS;
              target_nxt = OFF_W'(off);
            end
          end
        end
        PH_EXTLEN: begin
          if (hit0) begin
            acc_nxt = {byte_value, 8'h00};
          end else if (hit1) begin
            off = SUM_W'(target_r) + SUM_W'(2);
            sum = off + SUM_W'(val16);
            ext_end_nxt = OFF_W'(sum);
            if (sum > lenx) begin
              phase_nxt = PH_IDLE;
            end else if (off + SUM_W'(4) <= sum) begin
              phase_nxt  = PH_EXTHDR;
              target_nxt = OFF_W'(off);
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_EXTHDR: begin
          if (hit0 || hit2) begin
            acc_nxt = {byte_value, 8'h00};
          end else if (hit1) begin
            ext_kind_nxt = val16;
          end else if (hit3) begin
            off = SUM_W'(target_r) + SUM_W'(4);
            sum = off + SUM_W'(val16);
            if (sum > extx) begin
              phase_nxt = PH_IDLE;
            end else if (ext_kind_r == EXT_SERVER_NAME) begin
              if (off + SUM_W'(5) > extx) begin
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt  = PH_SNIHDR;
                target_nxt = OFF_W'(off);
              end
            end else if (sum + SUM_W'(4) <= extx) begin
              phase_nxt  = PH_EXTHDR;
              target_nxt = OFF_W'(sum);
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_SNIHDR: begin
          if (hit2) begin
            if (byte_value != HOST_NAME_TYPE) begin
              phase_nxt = PH_IDLE;
            end
          end else if (hit3) begin
            acc_nxt = {byte_value, 8'h00};
          end else if (hit4) begin
            off = SUM_W'(target_r) + SUM_W'(5);
            sum = off + SUM_W'(val16);
            if (sum > extx || val16 == 16'd0) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt    = PH_NAME;
              target_nxt   = OFF_W'(off);
              name_end_nxt = OFF_W'(sum);
            end
          end
        end
        PH_NAME: begin
          if (in_name && name_fin) begin
            found_nxt     = 1'b1;
            found_len_nxt = name_len_now;
            phase_nxt     = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
      // Saturating byte count
      if (pos_r != 16'hFFFF) begin
        pos_nxt = pos_r + 16'd1;
      end
      // End of packet: back to the record header
      if (packet_last) begin
        phase_nxt     = PH_HEADER;
        pos_nxt       = '0;
        held_nxt      = '0;
        target_nxt    = '0;
        acc_nxt       = '0;
        ext_end_nxt   = '0;
        ext_kind_nxt  = '0;
        name_end_nxt  = '0;
        found_nxt     = 1'b0;
        found_len_nxt = '0;
      end
    end
  end

  // Queued word for this byte
  always_comb begin
    entry.has_name    = accept && in_name;
    entry.name_byte   = byte_value;
    entry.name_last   = name_fin;
    entry.has_verdict = accept && packet_last;
    entry.found       = found_r || (in_name && name_fin);
    if (found_r) begin
      entry.name_length = found_len_r;
    end else if (in_name && name_fin) begin
      entry.name_length = name_len_now;
    end else begin
      entry.name_length = '0;
    end
    push = entry.has_name || entry.has_verdict;
  end

  // Parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      held_r      <= '0;
      target_r    <= '0;
      acc_r       <= '0;
      ext_end_r   <= '0;
      ext_kind_r  <= '0;
      name_end_r  <= '0;
      found_r     <= 1'b0;
      found_len_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      held_r      <= held_nxt;
      target_r    <= target_nxt;
      acc_r       <= acc_nxt;
      ext_end_r   <= ext_end_nxt;
      ext_kind_r  <= ext_kind_nxt;
      name_end_r  <= name_end_nxt;
      found_r     <= found_nxt;
      found_len_r <= found_len_nxt;
    end
  end

endmodule

// ===== hdl/tlssni_queue.sv =====
// Short word queue between the parser and the output side.
module tlssni_queue
  import tlssni_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output qstat_t stat
);

  entry_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_entry;
    end
  end

  assign head       = slot_r[rd_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.valid = (cnt_r != '0);
  assign stat.count = cnt_r;

endmodule

// ===== hdl/tlssni_back.sv =====
// Output side: turns queued words into result words behind an output register.
module tlssni_back
  import tlssni_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  entry_t      head,
  input  logic        head_valid,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        out_result_kind,
  output logic [7:0]  out_name_byte,
  output logic        out_name_last,
  output logic        out_found,
  output logic [15:0] out_name_length
);

  logic        valid_r, valid_nxt;
  logic        half_r, half_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic        found_r, found_nxt;
  logic [15:0] len_r, len_nxt;
  logic        load;

  // Output register is free when empty or being taken
  assign load = head_valid && (!valid_r || !out_stall);

  // Pick the name part first, then the verdict part of a word
  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    kind_nxt  = kind_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    found_nxt = found_r;
    len_nxt   = len_r;
    pop       = 1'b0;
    if (!valid_r || !out_stall) begin
      valid_nxt = head_valid;
    end
    if (load) begin
      if (head.has_name && !half_r) begin
        kind_nxt  = KIND_NAME;
        byte_nxt  = head.name_byte;
        last_nxt  = head.name_last;
        found_nxt = 1'b0;
        len_nxt   = '0;
        if (head.has_verdict) begin
          half_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        kind_nxt  = KIND_VERDICT;
        byte_nxt  = '0;
        last_nxt  = 1'b0;
        found_nxt = head.found;
        len_nxt   = head.name_length;
        half_nxt  = 1'b0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    found_r <= found_nxt;
    len_r   <= len_nxt;
  end

  assign out_valid       = valid_r;
  assign out_result_kind = kind_r;
  assign out_name_byte   = byte_r;
  assign out_name_last   = last_r;
  assign out_found       = found_r;
  assign out_name_length = len_r;

endmodule

// ===== test/tb_tls_client_hello_sni_extractor_unit.sv =====
// Self-checking testbench for the TLS ClientHello server name extractor.
module tb_tls_client_hello_sni_extractor_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tlssni_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_WORDS   = 50;
  // Sender idle and receiver stall percentages, one pair per phase
  localparam int IDLE_PCT [4]  = '{0, 72, 0, 31};
  localparam int STALL_PCT [4] = '{0, 0, 72, 31};

  typedef logic [7:0] octet_q [$];

  typedef struct packed {
    logic [7:0]  value;
    logic [15:0] cap_len;
    logic        is_final;
  } feed_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic        name_last;
    logic        found;
    logic [15:0] name_length;
  } sni_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = 8'h00;
  logic [15:0] in_payload_length = 16'h0000;
  logic        in_packet_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_name_byte;
  logic        out_name_last;
  logic        out_found;
  logic [15:0] out_name_length;

  feed_word_t  word_feed [$];
  sni_result_t sni_results_due [$];
  int          queued_words = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_requests = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  // Parser state as the block should hold it
  phase_t      parse_at = PH_HEADER;
  int unsigned byte_pos = 0;
  int unsigned cap_held = 0;
  int unsigned field_at = 0;
  int unsigned accum = 0;
  int unsigned ext_end = 0;
  int unsigned ext_kind = 0;
  int unsigned name_stop = 0;
  bit          name_done = 1'b0;
  int unsigned name_count = 0;

  tls_client_hello_sni_extractor_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte_value     (in_byte_value),
    .in_payload_length (in_payload_length),
    .in_packet_last    (in_packet_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_name_byte     (out_name_byte),
    .out_name_last     (out_name_last),
    .out_found         (out_found),
    .out_name_length   (out_name_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void restart_packet();
    parse_at   = PH_HEADER;
    byte_pos   = 0;
    cap_held   = 0;
    field_at   = 0;
    accum      = 0;
    ext_end    = 0;
    ext_kind   = 0;
    name_stop  = 0;
    name_done  = 1'b0;
    name_count = 0;
  endfunction

  // Move to the next extension header if a whole one still fits
  function automatic void next_extension(int unsigned off);
    if (off + 4 <= ext_end) begin
      parse_at = PH_EXTHDR;
      field_at = off;
    end else begin
      parse_at = PH_IDLE;
    end
  endfunction

  // Queue one expected result at the tail
  function automatic void expect_result(sni_result_t r);
    sni_results_due.insert(sni_results_due.size(), r);
  endfunction

  // Work out the results that one accepted word causes
  task automatic predict_sni(input logic [7:0] b, input logic [15:0] cap_in,
                             input logic is_final);
    int unsigned pos, len, off, d, fieldv;
    bit fin;
    pos = byte_pos;
    if (pos == 0) cap_held = 32'(cap_in & LEN_MASK);
    len = cap_held;
    d = (pos >= field_at) ? pos - field_at : 32'hFFFF_FFFF;
    case (parse_at)
      PH_HEADER: begin
        if (pos == 0) begin
          if (len < MIN_RECORD || b != TLS_HANDSHAKE) parse_at = PH_IDLE;
        end else if (pos == 3) begin
          accum = 32'({b, 8'h00});
        end else if (pos == 4) begin
          accum |= 32'(b);
        end else if (pos == 5) begin
          if (5 + accum > len || b != HS_CLIENT_HELLO || SESSION_ID_AT >= len) begin
            parse_at = PH_IDLE;
          end else begin
            parse_at = PH_SESSION;
            field_at = SESSION_ID_AT;
          end
        end
      end
      PH_SESSION: begin
        if (d == 0) begin
          off = field_at + 1 + 32'(b);
          if (off + 2 > len) begin
            parse_at = PH_IDLE;
          end else begin
            parse_at = PH_CIPHERS;
            field_at = off;
          end
        end
      end
      PH_CIPHERS: begin
        if (d == 0) begin
          accum = 32'({b, 8'h00});
        end else if (d == 1) begin
          off = field_at + 2 + (accum | 32'(b));
          if (off + 1 > len) begin
            parse_at = PH_IDLE;
          end else begin
            parse_at = PH_COMPRESS;
            field_at = off;
          end
        end
      end
      PH_COMPRESS: begin
        if (d == 0) begin
          off = field_at + 1 + 32'(b);
          if (off + 2 > len) begin
            parse_at = PH_IDLE;
          end else begin
            parse_at = PH_EXTLEN;
            field_at = off;
          end
        end
      end
      PH_EXTLEN: begin
        if (d == 0) begin
          accum = 32'({b, 8'h00});
        end else if (d == 1) begin
          off = field_at + 2;
          ext_end = off + (accum | 32'(b));
          if (ext_end > len) parse_at = PH_IDLE;
          else next_extension(off);
        end
      end
      PH_EXTHDR: begin
        if (d == 0) begin
          accum = 32'({b, 8'h00});
        end else if (d == 1) begin
          ext_kind = accum | 32'(b);
        end else if (d == 2) begin
          accum = 32'({b, 8'h00});
        end else if (d == 3) begin
          fieldv = accum | 32'(b);
          off = field_at + 4;
          if (off + fieldv > ext_end) begin
            parse_at = PH_IDLE;
          end else if (ext_kind == EXT_SERVER_NAME) begin
            if (off + 5 > ext_end) begin
              parse_at = PH_IDLE;
            end else begin
              parse_at = PH_SNIHDR;
              field_at = off;
            end
          end else begin
            next_extension(off + fieldv);
          end
        end
      end
      PH_SNIHDR: begin
        if (d == 2) begin
          if (b != HOST_NAME_TYPE) parse_at = PH_IDLE;
        end else if (d == 3) begin
          accum = 32'({b, 8'h00});
        end else if (d == 4) begin
          fieldv = accum | 32'(b);
          off = field_at + 5;
          if (off + fieldv > ext_end || fieldv == 0) begin
            parse_at = PH_IDLE;
          end else begin
            parse_at  = PH_NAME;
            field_at  = off;
            name_stop = off + fieldv;
          end
        end
      end
      PH_NAME: begin
        if (pos >= field_at && pos < name_stop) begin
          fin = (pos + 1 == name_stop);
          expect_result('{kind: KIND_NAME, name_byte: b, name_last: fin,
                          found: 1'b0, name_length: 16'h0000});
          if (fin) begin
            name_done  = 1'b1;
            name_count = (name_stop - field_at) & 32'(LEN_MASK);
            parse_at   = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
    if (byte_pos < 32'hFFFF) byte_pos++;
    // Verdict closes the packet
    if (is_final) begin
      expect_result('{kind: KIND_VERDICT, name_byte: 8'h00, name_last: 1'b0,
                      found: name_done,
                      name_length: name_done ? 16'(name_count) : 16'h0000});
      restart_packet();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] want);
    $display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $time, what, seen, want);
    mismatches++;
  endtask

  // Append one octet at the tail of a byte list
  task automatic append_octet(ref octet_q q, input logic [7:0] v);
    q.insert(q.size(), v);
  endtask

  task automatic push16(ref octet_q q, input logic [15:0] v);
    append_octet(q, v[15:8]);
    append_octet(q, v[7:0]);
  endtask

  // Extension of some other type with random content
  task automatic add_other_ext(ref octet_q q);
    int n;
    n = $urandom_range(0, 6);
    push16(q, 16'($urandom_range(1, 16'hFFFF)));
    push16(q, 16'(n));
    repeat (n) append_octet(q, 8'($urandom));
  endtask

  // Well-formed ClientHello record with random content
  task automatic build_client_hello(ref octet_q pkt, input int name_len, input bit with_sni,
                                    input logic [7:0] host_type, input int exts_before,
                                    input int exts_after, input int tail);
    octet_q exts, hello;
    int n;
    pkt.delete();
    repeat (exts_before) add_other_ext(exts);
    if (with_sni) begin
      push16(exts, EXT_SERVER_NAME);
      push16(exts, 16'(name_len + 5));
      push16(exts, 16'(name_len + 3));
      append_octet(exts, host_type);
      push16(exts, 16'(name_len));
      repeat (name_len) append_octet(exts, 8'($urandom));
    end
    repeat (exts_after) add_other_ext(exts);
    append_octet(hello, 8'h03);
    append_octet(hello, 8'h03);
    repeat (32) append_octet(hello, 8'($urandom));
    // session id, mostly short
    n = ($urandom_range(3) == 0) ? $urandom_range(32) : $urandom_range(4);
    append_octet(hello, 8'(n));
    repeat (n) append_octet(hello, 8'($urandom));
    n = 2 * $urandom_range(1, 3);
    push16(hello, 16'(n));
    repeat (n) append_octet(hello, 8'($urandom));
    n = $urandom_range(1, 2);
    append_octet(hello, 8'(n));
    repeat (n) append_octet(hello, 8'($urandom));
    push16(hello, 16'(exts.size()));
    hello = {hello, exts};
    pkt = {TLS_HANDSHAKE, 8'h03, 8'h01};
    push16(pkt, 16'(hello.size() + 4));
    append_octet(pkt, HS_CLIENT_HELLO);
    append_octet(pkt, 8'h00);
    push16(pkt, 16'(hello.size()));
    pkt = {pkt, hello};
    repeat (tail) append_octet(pkt, 8'($urandom));
  endtask

  // Only the first word's length counts; the rest carry noise there
  task automatic queue_packet(input octet_q pkt, input logic [15:0] cap);
    foreach (pkt[i]) begin
      word_feed.insert(word_feed.size(),
                       feed_word_t'{value: pkt[i], cap_len: (i == 0) ? cap : 16'($urandom),
                                    is_final: (i == pkt.size() - 1)});
    end
    queued_words += pkt.size();
  endtask

  task automatic queue_random_packet();
    octet_q pkt;
    int sel, n;
    logic [15:0] cap;
    sel = $urandom_range(99);
    if (sel < 14) begin
      // short noise, half of it with a handshake record type
      n = $urandom_range(1, 12);
      repeat (n) append_octet(pkt, 8'($urandom));
      if ($urandom_range(1)) pkt[0] = TLS_HANDSHAKE;
      cap = $urandom_range(1) ? 16'(n) : 16'($urandom);
    end else begin
      build_client_hello(pkt, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 24),
                         $urandom_range(9) != 0,
                         ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255))
                                                  : HOST_NAME_TYPE,
                         $urandom_range(2),
                         ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0,
                         ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
      cap = 16'(pkt.size());
      if (sel < 24) pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom);
      else if (sel < 32) pkt = pkt[0:$urandom_range(pkt.size() - 1)];
      else if (sel < 40) cap = 16'($urandom_range(pkt.size() - 1));
      else if (sel < 46) cap = 16'($urandom_range(pkt.size(), 16'hFFFF));
    end
    queue_packet(pkt, cap);
  endtask

  task wait_drained();
    while (word_feed.size() != 0 || in_valid || sni_results_due.size() != 0)
      @(negedge clk);
  endtask

  // Driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk) begin
    feed_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        predict_sni(in_byte_value, in_payload_length, in_packet_last);
      if (!in_valid || !in_stall) begin
        if (word_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = word_feed.pop_front();
          in_valid          <= 1'b1;
          in_byte_value     <= w.value;
          in_payload_length <= w.cap_len;
          in_packet_last    <= w.is_final;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  // Monitor: compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    sni_result_t got, due;
    if (rst_n && out_valid && !out_stall) begin
      got = '{kind: out_result_kind, name_byte: out_name_byte, name_last: out_name_last,
              found: out_found, name_length: out_name_length};
      if (sni_results_due.size() == 0) begin
        report_mismatch("result with none due", 32'(got), 32'h0);
      end else begin
        due = sni_results_due.pop_front();
        if (got.kind !== due.kind)
          report_mismatch("result_kind", 32'(got.kind), 32'(due.kind));
        if (got.name_byte !== due.name_byte)
          report_mismatch("name_byte", 32'(got.name_byte), 32'(due.name_byte));
        if (got.name_last !== due.name_last)
          report_mismatch("name_last", 32'(got.name_last), 32'(due.name_last));
        if (got.found !== due.found)
          report_mismatch("found", 32'(got.found), 32'(due.found));
        if (got.name_length !== due.name_length)
          report_mismatch("name_length", 32'(got.name_length), 32'(due.name_length));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tls_client_hello_sni_extractor_unit test failed");
      $finish;
    end
  end

  initial begin
    octet_q pkt;
    int base, full_size;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-word packets: field extremes and a record too short to hold a header
    pkt = {8'h00};
    queue_packet(pkt, 16'h0000);
    pkt = {8'hFF};
    queue_packet(pkt, 16'hFFFF);
    pkt = {TLS_HANDSHAKE};
    queue_packet(pkt, 16'd8);
    // one-character name ending on the packet's final word
    build_client_hello(pkt, 1, 1'b1, HOST_NAME_TYPE, 0, 0, 0);
    queue_packet(pkt, 16'(pkt.size()));
    // no server name at all, largest captured length, trailing words
    build_client_hello(pkt, 0, 1'b0, HOST_NAME_TYPE, 2, 0, 3);
    queue_packet(pkt, 16'hFFFF);
    // first entry of another name type, further extensions behind it
    build_client_hello(pkt, 6, 1'b1, 8'h01, 0, 2, 0);
    queue_packet(pkt, 16'(pkt.size()));
    // empty host name
    build_client_hello(pkt, 0, 1'b1, HOST_NAME_TYPE, 1, 0, 0);
    queue_packet(pkt, 16'(pkt.size()));
    // packet ends three words before the name is complete
    build_client_hello(pkt, 8, 1'b1, HOST_NAME_TYPE, 1, 0, 0);
    full_size = pkt.size();
    pkt = pkt[0:pkt.size() - 4];
    queue_packet(pkt, 16'(full_size));
    // captured length stops inside the name
    build_client_hello(pkt, 8, 1'b1, HOST_NAME_TYPE, 0, 0, 2);
    queue_packet(pkt, 16'(pkt.size() - 6));
    // handshake that is not a ClientHello
    build_client_hello(pkt, 4, 1'b1, HOST_NAME_TYPE, 0, 0, 0);
    pkt[5] = 8'h02;
    queue_packet(pkt, 16'(pkt.size()));
    // ordinary name between other extensions, trailing words
    build_client_hello(pkt, 12, 1'b1, HOST_NAME_TYPE, 1, 1, 2);
    queue_packet(pkt, 16'(pkt.size()));
    wait_drained();

    // random packets under each idling pattern; the first phase opens with a hold-off
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = IDLE_PCT[ph];
      stall_pct     = STALL_PCT[ph];
      if (ph == 0) hold_requests++;
      base = queued_words;
      while (queued_words - base < PHASE_WORDS) queue_random_packet();
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tls_client_hello_sni_extractor_unit test passed");
    end else begin
      $display("tls_client_hello_sni_extractor_unit test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tlssni_pkg.sv
hdl/tlssni_front.sv
hdl/tlssni_queue.sv
hdl/tlssni_back.sv
hdl/tls_client_hello_sni_extractor_unit.sv
test/tb_tls_client_hello_sni_extractor_unit.sv
